// ===== rtl/core/lle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list engine package
// Request and response words, opcodes, status codes, sequencer states and
// the small control groups passed between the engine's modules.
// ----------------------------------------------------------------------------
package lle_pkg;

	typedef enum logic [2:0] {
		OP_PREPEND = 3'd0,
		OP_APPEND  = 3'd1,
		OP_DELETE  = 3'd2,
		OP_FIND    = 3'd3,
		OP_GET     = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_WALK,
		S_INSERT,
		S_LINK,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] value;
		logic [5:0]         index;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value_out;
		logic [5:0]         position;
		logic [6:0]         count;
	} rsp_t;

	// Compare results of the walk unit for the node currently read.
	typedef struct packed {
		logic at_end;
		logic match;
		logic at_first;
		logic at_last;
		logic at_index;
		logic in_range;
	} walk_flags_t;

	// Write enables of the node store.
	typedef struct packed {
		logic value;
		logic link;
		logic free_push;
	} store_we_t;

endpackage

// ===== rtl/core/linked_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list engine
// Bounded singly linked list of signed words with prepend, append, delete,
// find and get-by-index requests, one response word per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request word on req is taken at a rising edge with start high and busy
//   low. busy stays high until the response has been shown. The response
//   word sits on rsp for exactly one cycle marked by done; the receiver must
//   take it then, as it cannot hold it off.
//   States after the accepting edge: issue, then
//     prepend, or append to an empty list: insert; append otherwise: insert, link;
//     full store, unused opcode, empty list or index out of range: nothing more;
//     delete, find and get: walk over the nodes passed before the hit or
//     the end of the list (at most the node count, 64 by default). All end in response.
//   The chain is walked one node per cycle through the registered read port
//   of the node memory. The next word is accepted only once the engine is
//   back in idle after the response.
//   Released slots go on a stack and are reused first; slots never used are
//   handed out by a fill counter, so reset needs no pass over the memories.
//   After reset the list is empty and the engine is idle.
// ----------------------------------------------------------------------------
module linked_list_engine #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lle_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output lle_pkg::rsp_t rsp
);
	import lle_pkg::*;

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	req_t                  req_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [SW-1:0]         head_q, tail_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         fresh_q;
	logic [CW-1:0]         fsp_q;
	logic [SW-1:0]         cur_q, prev_q, slot_q;
	logic [CW-1:0]         i_q;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] vout_q;
	logic [CW-1:0]         pos_q;

	logic [63:0]           value_sx;
	logic [DATA_WIDTH-1:0] data_in;
	logic [DATA_WIDTH+31:0] vout_x;
	logic [CW+5:0]         pos_x;
	logic [CW+6:0]         count_x;

	store_we_t             we;
	logic [SW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_value;
	logic [SW-1:0]         rd_link;
	logic [SW-1:0]         val_wr_addr;
	logic [SW-1:0]         link_wr_addr, link_wr_data;
	logic [SW-1:0]         fs_wr_addr, fs_rd_addr, fs_rd_data;
	logic [CW-1:0]         fsp_m1;
	logic [SW-1:0]         new_slot;

	walk_flags_t           flags;
	logic [CW-1:0]         next_i;

	logic is_insert, is_search, is_delete, is_get, is_prepend, is_append;
	logic full, hit;

	// ------------------------------------------------------------------
	// Decode and width adaption
	// ------------------------------------------------------------------
	assign value_sx = {{32{req.value[31]}}, req.value};
	assign data_in  = value_sx[DATA_WIDTH-1:0];
	assign vout_x   = {32'b0, vout_q};
	assign pos_x    = {6'b0, pos_q};
	assign count_x  = {7'b0, count_q};

	assign is_prepend = (req_q.opcode == OP_PREPEND);
	assign is_append  = (req_q.opcode == OP_APPEND);
	assign is_insert  = is_prepend || is_append;
	assign is_delete  = (req_q.opcode == OP_DELETE);
	assign is_search  = is_delete || (req_q.opcode == OP_FIND);
	assign is_get     = (req_q.opcode == OP_GET);

	assign full     = (count_q == CW'(CAPACITY));
	assign hit      = !flags.at_end && flags.match;
	assign fsp_m1   = fsp_q - 1'b1;
	assign new_slot = (fsp_q != '0) ? fs_rd_data : fresh_q[SW-1:0];

	// ------------------------------------------------------------------
	// Shared walk unit and node store
	// ------------------------------------------------------------------
	lle_walk_unit #(
		.DATA_WIDTH(DATA_WIDTH),
		.CW        (CW)
	) u_walk (
		.step      (i_q),
		.count     (count_q),
		.index     (req_q.index),
		.node_value(rd_value),
		.key       (data_q),
		.flags     (flags),
		.next_step (next_i)
	);

	lle_node_store #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH),
		.SW        (SW)
	) u_store (
		.clk         (clk),
		.we          (we),
		.rd_addr     (rd_addr),
		.rd_value    (rd_value),
		.rd_link     (rd_link),
		.val_wr_addr (val_wr_addr),
		.val_wr_data (data_q),
		.link_wr_addr(link_wr_addr),
		.link_wr_data(link_wr_data),
		.fs_wr_addr  (fs_wr_addr),
		.fs_wr_data  (cur_q),
		.fs_rd_addr  (fs_rd_addr),
		.fs_rd_data  (fs_rd_data)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				unique case (req_q.opcode) inside
					OP_PREPEND, OP_APPEND: state_d = full ? S_RESP : S_INSERT;
					OP_DELETE, OP_FIND:    state_d = (count_q == '0) ? S_RESP : S_WALK;
					OP_GET:                state_d = flags.in_range ? S_WALK : S_RESP;
					default:               state_d = S_RESP;
				endcase
			end
			S_WALK: begin
				if (is_get ? flags.at_index : (flags.at_end || flags.match)) begin
					state_d = S_RESP;
				end
			end
			S_INSERT: state_d = (is_append && count_q != '0) ? S_LINK : S_RESP;
			S_LINK:   state_d = S_RESP;
			S_RESP:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy         = (state_q != S_IDLE);
		done         = (state_q == S_RESP);
		we           = '0;
		rd_addr      = (state_q == S_WALK) ? rd_link : head_q;
		fs_rd_addr   = (fsp_q != '0) ? fsp_m1[SW-1:0] : '0;
		fs_wr_addr   = fsp_q[SW-1:0];
		val_wr_addr  = new_slot;
		link_wr_addr = new_slot;
		link_wr_data = '0;
		unique case (state_q)
			S_INSERT: begin
				we.value = 1'b1;
				we.link  = 1'b1;
				if (is_prepend && count_q != '0) begin
					link_wr_data = head_q;
				end
			end
			S_LINK: begin
				we.link      = 1'b1;
				link_wr_addr = tail_q;
				link_wr_data = slot_q;
			end
			S_WALK: begin
				if (is_delete && hit) begin
					we.free_push = 1'b1;
					// Unlink from the predecessor unless the head goes.
					if (!flags.at_first) begin
						we.link      = 1'b1;
						link_wr_addr = prev_q;
						link_wr_data = rd_link;
					end
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// List state and result registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			fresh_q  <= '0;
			fsp_q    <= '0;
			status_q <= ST_MISS;
			vout_q   <= '0;
			pos_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_ISSUE: begin
					vout_q <= '0;
					pos_q  <= '0;
					if (is_insert) begin
						status_q <= full ? ST_FULL : ST_OK;
					end else begin
						status_q <= ST_MISS;
					end
				end
				S_WALK: begin
					if (is_get ? flags.at_index : (is_search && hit)) begin
						status_q <= ST_OK;
						vout_q   <= rd_value;
						pos_q    <= i_q;
					end
					if (is_delete && hit) begin
						if (flags.at_first) begin
							head_q <= rd_link;
						end else if (flags.at_last) begin
							tail_q <= prev_q;
						end
						fsp_q   <= fsp_q + 1'b1;
						count_q <= count_q - 1'b1;
						if (count_q == CW'(1)) begin
							head_q <= '0;
							tail_q <= '0;
						end
					end
				end
				S_INSERT: begin
					if (fsp_q != '0) begin
						fsp_q <= fsp_m1;
					end else begin
						fresh_q <= fresh_q + 1'b1;
					end
					count_q <= count_q + 1'b1;
					if (count_q == '0) begin
						head_q <= new_slot;
						tail_q <= new_slot;
					end else if (is_prepend) begin
						head_q <= new_slot;
					end
				end
				S_LINK: begin
					tail_q <= slot_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q  <= req;
					data_q <= data_in;
				end
			end
			S_ISSUE: begin
				cur_q  <= head_q;
				prev_q <= head_q;
				i_q    <= '0;
			end
			S_WALK: begin
				prev_q <= cur_q;
				cur_q  <= rd_link;
				i_q    <= next_i;
			end
			S_INSERT: begin
				slot_q <= new_slot;
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp.status    = status_q;
		rsp.value_out = vout_x[31:0];
		rsp.position  = pos_x[5:0];
		rsp.count     = count_x[6:0];
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_matches_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'(fresh_q - fsp_q))
		else $error("node count differs from allocated slots");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("node count beyond capacity");

	a_empty_pointers: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> head_q == '0 && tail_q == '0)
		else $error("empty list with nonzero head or tail");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> i_q <= count_q)
		else $error("walk passed the end of the list");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("response strobe longer than one cycle");

endmodule

// ===== rtl/core/lle_node_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list engine node store
// Node value memory, node link memory and the stack of released slots, each
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lle_node_store #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32,
	parameter int SW         = 6
) (
	input  logic                  clk,
	input  lle_pkg::store_we_t    we,
	input  logic [SW-1:0]         rd_addr,
	output logic [DATA_WIDTH-1:0] rd_value,
	output logic [SW-1:0]         rd_link,
	input  logic [SW-1:0]         val_wr_addr,
	input  logic [DATA_WIDTH-1:0] val_wr_data,
	input  logic [SW-1:0]         link_wr_addr,
	input  logic [SW-1:0]         link_wr_data,
	input  logic [SW-1:0]         fs_wr_addr,
	input  logic [SW-1:0]         fs_wr_data,
	input  logic [SW-1:0]         fs_rd_addr,
	output logic [SW-1:0]         fs_rd_data
);
	import lle_pkg::*;

	logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
	logic [SW-1:0]         link_mem [CAPACITY];
	logic [SW-1:0]         free_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we.value) begin
			val_mem[val_wr_addr] <= val_wr_data;
		end
		rd_value <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we.link) begin
			link_mem[link_wr_addr] <= link_wr_data;
		end
		rd_link <= link_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we.free_push) begin
			free_mem[fs_wr_addr] <= fs_wr_data;
		end
		fs_rd_data <= free_mem[fs_rd_addr];
	end

endmodule

// ===== rtl/core/lle_walk_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list engine walk unit
// Shared compare and step logic used once per visited node: value match,
// position against count and index, and the next position.
// ----------------------------------------------------------------------------
module lle_walk_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int CW         = 7
) (
	input  logic [CW-1:0]          step,
	input  logic [CW-1:0]          count,
	input  logic [5:0]             index,
	input  logic [DATA_WIDTH-1:0]  node_value,
	input  logic [DATA_WIDTH-1:0]  key,
	output lle_pkg::walk_flags_t   flags,
	output logic [CW-1:0]          next_step
);
	import lle_pkg::*;

	logic [CW+5:0] step_x;
	logic [CW+5:0] count_x;
	logic [CW+5:0] index_x;

	assign step_x    = {{6{1'b0}}, step};
	assign count_x   = {{6{1'b0}}, count};
	assign index_x   = {{CW{1'b0}}, index};
	assign next_step = step + 1'b1;

	always_comb begin
		flags.at_end   = (step == count);
		flags.match    = (node_value == key);
		flags.at_first = (step == '0);
		flags.at_last  = (next_step == count);
		flags.at_index = (step_x == index_x);
		flags.in_range = (index_x < count_x);
	end

endmodule
